FILE: hdl/slm_pkg.sv
package slm_pkg;

   // pattern storage as the register map lays it out
   localparam int BYTE_WIDTH      = 8;
   localparam int WORD_WIDTH      = 64;
   localparam int PATTERN_WORDS   = 4;
   localparam int BYTES_PER_WORD  = WORD_WIDTH / BYTE_WIDTH;
   localparam int PATTERN_BYTES   = PATTERN_WORDS * BYTES_PER_WORD;
   localparam int LENGTH_WIDTH    = 6;
   localparam int CSR_INDEX_WIDTH = 3;

   // default number of match cells
   localparam int MAX_PATTERN_DEFAULT = 32;

   typedef logic [BYTE_WIDTH-1:0] byte_type;

   // register indexes of the configuration port
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_PATTERN_WORD_ZERO  = 3'd0,
      REG_PATTERN_WORD_ONE   = 3'd1,
      REG_PATTERN_WORD_TWO   = 3'd2,
      REG_PATTERN_WORD_THREE = 3'd3,
      REG_PATTERN_LENGTH     = 3'd4
   } csr_index_type;

   // control that every cell of the chain sees
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

endpackage

FILE: hdl/substring_line_matcher.sv
// Line substring matcher. Send the bytes of a text line one word at a time
// on the req channel; the word that carries req_line_end returns one rsp
// word whose rsp_line_match tells whether the configured pattern occurred
// in that line. A zero byte ends the line's text, and later bytes up to the
// line end are ignored. A row of MAX_PATTERN window cells holds the newest
// text bytes and shifts them one place per byte, and each cell compares the
// byte arriving at it with the pattern byte that the current length lines up
// with its position, so the whole pattern is checked in the cycle the byte is
// taken. A word is taken in every cycle while the rsp register is empty or
// drained. Line results are registered and appear in the cycle after the line
// end. A register write applies to the bytes taken after its write edge.
module substring_line_matcher #(
   parameter int MAX_PATTERN = slm_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input words
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [slm_pkg::BYTE_WIDTH-1:0]         req_text_byte,
   input  logic                                   req_byte_present,
   input  logic                                   req_line_end,
   // result words
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_line_match,
   // configuration
   input  logic                                   csr_write_en,
   input  logic [slm_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [slm_pkg::WORD_WIDTH-1:0]         csr_wdata
);

   localparam int LEN_W     = slm_pkg::LENGTH_WIDTH + 1;
   localparam int PAT_IDX_W = $clog2(slm_pkg::PATTERN_BYTES);

   logic [slm_pkg::PATTERN_WORDS-1:0][slm_pkg::WORD_WIDTH-1:0] pattern_ff;
   logic [slm_pkg::LENGTH_WIDTH-1:0] length_ff;

   logic text_ended_ff, text_ended_in;
   logic found_ff, found_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_line_match_ff, rsp_line_match_in;

   logic req_accept;
   logic take_byte;
   logic hit;
   logic [LEN_W-1:0] len_ext;
   logic [LEN_W-1:0] used_len;

   slm_pkg::cell_ctrl_type cell_ctrl;
   slm_pkg::byte_type      pattern_bytes [slm_pkg::PATTERN_BYTES];
   slm_pkg::byte_type      link_byte [MAX_PATTERN+1];
   logic [MAX_PATTERN:0]   link_full;
   logic [MAX_PATTERN-1:0] in_use;
   logic [MAX_PATTERN-1:0] equal;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= slm_pkg::LENGTH_WIDTH'(1);
      end else if (csr_write_en) begin
         unique case (slm_pkg::csr_index_type'(csr_index))
            slm_pkg::REG_PATTERN_WORD_ZERO:  pattern_ff[0] <= csr_wdata;
            slm_pkg::REG_PATTERN_WORD_ONE:   pattern_ff[1] <= csr_wdata;
            slm_pkg::REG_PATTERN_WORD_TWO:   pattern_ff[2] <= csr_wdata;
            slm_pkg::REG_PATTERN_WORD_THREE: pattern_ff[3] <= csr_wdata;
            slm_pkg::REG_PATTERN_LENGTH:
               length_ff <= csr_wdata[slm_pkg::LENGTH_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // handshake: the rsp register parts the two sides
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign take_byte  = req_accept && req_byte_present && !text_ended_ff;

   assign cell_ctrl.shift = take_byte && (req_text_byte != '0);
   assign cell_ctrl.clear = req_accept && req_line_end;

   // pattern bytes in register order, byte 0 first
   for (genvar p = 0; p < slm_pkg::PATTERN_BYTES; p++) begin : g_pat_byte
      assign pattern_bytes[p] = pattern_ff[p / slm_pkg::BYTES_PER_WORD]
         [(p % slm_pkg::BYTES_PER_WORD) * slm_pkg::BYTE_WIDTH +: slm_pkg::BYTE_WIDTH];
   end

   // used length, saturated to the cell count
   assign len_ext  = {1'b0, length_ff};
   assign used_len = (len_ext > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_ext;

   // new byte enters the head of the row
   assign link_byte[0] = req_text_byte;
   assign link_full[0] = 1'b1;

   // row of window cells, cell k sees the k-th newest byte after the shift
   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      logic [LEN_W-1:0]  pos;
      slm_pkg::byte_type pat_byte;

      // newest byte lines up with the last pattern byte
      assign in_use[k] = LEN_W'(k) < used_len;
      assign pos       = used_len - LEN_W'(k + 1);
      assign pat_byte  = (pos < LEN_W'(slm_pkg::PATTERN_BYTES))
                       ? pattern_bytes[pos[PAT_IDX_W-1:0]] : '0;

      slm_match_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (cell_ctrl),
         .byte_prev    (link_byte[k]),
         .full_prev    (link_full[k]),
         .pattern_byte (pat_byte),
         .byte_out     (link_byte[k+1]),
         .full_out     (link_full[k+1]),
         .equal        (equal[k])
      );
   end

   // every position in use must hold its pattern byte
   assign hit = cell_ctrl.shift && (used_len != '0) && (&(equal | ~in_use));

   // line state and result register
   always_comb begin
      text_ended_in     = text_ended_ff;
      found_in          = found_ff || hit;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_line_match_in = rsp_line_match_ff;
      if (take_byte && (req_text_byte == '0)) begin
         text_ended_in = 1'b1;
      end
      if (cell_ctrl.clear) begin
         rsp_valid_in      = 1'b1;
         rsp_line_match_in = found_in || (used_len == '0);
         text_ended_in     = 1'b0;
         found_in          = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_ended_ff <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         text_ended_ff <= text_ended_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_line_match_ff <= rsp_line_match_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_match = rsp_line_match_ff;

endmodule

FILE: hdl/slm_match_cell.sv
module slm_match_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  slm_pkg::cell_ctrl_type ctrl,
   input  slm_pkg::byte_type      byte_prev,
   input  logic                   full_prev,
   input  slm_pkg::byte_type      pattern_byte,
   output slm_pkg::byte_type      byte_out,
   output logic                   full_out,
   output logic                   equal
);

   slm_pkg::byte_type byte_ff;
   slm_pkg::byte_type byte_in;
   logic              full_ff;
   logic              full_in;

   // the byte coming from the neighbor is this position's text byte after the shift
   assign equal = full_prev && (byte_prev == pattern_byte);

   always_comb begin
      byte_in = byte_ff;
      full_in = full_ff;
      if (ctrl.clear) begin
         byte_in = '0;
         full_in = 1'b0;
      end else if (ctrl.shift) begin
         byte_in = byte_prev;
         full_in = full_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
         full_ff <= 1'b0;
      end else begin
         byte_ff <= byte_in;
         full_ff <= full_in;
      end
   end

   assign byte_out = byte_ff;
   assign full_out = full_ff;

endmodule

FILE: tb/line_match_checker.sv
`timescale 1ns / 100ps

module line_match_checker #(
   parameter int MAX_PATTERN = slm_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [slm_pkg::BYTE_WIDTH-1:0]      req_text_byte,
   input  logic                                req_byte_present,
   input  logic                                req_line_end,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic                                rsp_line_match,
   input  logic                                csr_write_en,
   input  logic [slm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [slm_pkg::WORD_WIDTH-1:0]      csr_wdata,
   output int                                  fail_count,
   output int                                  pending_count
);
   import slm_pkg::*;

   // keeps the log readable when the block is badly broken
   localparam int REPORT_LIMIT = 200;

   // shadow copy of the pattern registers
   logic [WORD_WIDTH-1:0]   pattern_words [PATTERN_WORDS];
   logic [LENGTH_WIDTH-1:0] pattern_len;

   // line state: newest text byte sits in window[0]
   byte_type    window [MAX_PATTERN];
   int unsigned fill_level;
   bit          found;
   bit          text_done;

   // line verdicts still owed by the block, oldest first
   bit expected_matches [$];
   int mismatches;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // lengths above the cell count saturate
   function automatic int unsigned active_length();
      if (pattern_len > MAX_PATTERN) return MAX_PATTERN;
      return pattern_len;
   endfunction

   function automatic byte_type pattern_byte(input int unsigned k);
      if (k >= PATTERN_BYTES) return '0;
      return pattern_words[k / BYTES_PER_WORD][(k % BYTES_PER_WORD) * BYTE_WIDTH +: BYTE_WIDTH];
   endfunction

   function automatic void clear_line();
      foreach (window[i]) window[i] = '0;
      fill_level = 0;
      found      = 1'b0;
      text_done  = 1'b0;
   endfunction

   // shift a text byte in and test the newest bytes against the whole pattern
   function automatic void shift_in(input byte_type value);
      int unsigned len;
      bit          equal;
      for (int i = MAX_PATTERN - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = value;
      if (fill_level < MAX_PATTERN) fill_level++;
      len = active_length();
      if (len == 0 || fill_level < len) return;
      equal = 1'b1;
      for (int unsigned k = 0; k < len; k++) begin
         if (pattern_byte(k) != window[len-1-k]) equal = 1'b0;
      end
      if (equal) found = 1'b1;
   endfunction

   // one accepted input word; a line end owes one verdict
   function automatic void take_word(input byte_type value, input logic present,
                                     input logic last);
      if (present && !text_done) begin
         if (value == '0) text_done = 1'b1;
         else shift_in(value);
      end
      if (last) begin
         expected_matches.push_back(found || active_length() == 0);
         clear_line();
      end
   endfunction

   // watch all three ports at each edge
   always @(posedge clock) begin : watch
      bit wanted;
      if (reset) begin
         foreach (pattern_words[w]) pattern_words[w] = '0;
         pattern_len = 1;
         clear_line();
         expected_matches.delete();
         mismatches = 0;
      end else begin
         // register writes
         if (csr_write_en) begin
            if (csr_index == REG_PATTERN_LENGTH)
               pattern_len = csr_wdata[LENGTH_WIDTH-1:0];
            else if (csr_index <= REG_PATTERN_WORD_THREE)
               pattern_words[csr_index[1:0]] = csr_wdata;
         end
         // result words come from earlier input words, so compare first
         if (rsp_valid && rsp_ready) begin
            if (expected_matches.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unexpected result word, expected none, actual line_match %0d",
                           $time, rsp_line_match);
            end else begin
               wanted = expected_matches.pop_front();
               if (rsp_line_match !== wanted) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("%0t: line_match mismatch, expected %0d, actual %0d",
                              $time, wanted, rsp_line_match);
               end
            end
         end
         if (req_valid && req_ready)
            take_word(req_text_byte, req_byte_present, req_line_end);
      end
      pending_count <= expected_matches.size();
      fail_count    <= mismatches;
   end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import slm_pkg::*;

   localparam int RANDOM_ITEMS  = 1700;
   localparam int PHASE_ITEMS   = 150;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 400000;

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_ready;
   logic [BYTE_WIDTH-1:0]      req_text_byte    = '0;
   logic                       req_byte_present = 1'b0;
   logic                       req_line_end     = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready        = 1'b0;
   logic                       rsp_line_match;
   logic                       csr_write_en     = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index        = REG_PATTERN_WORD_ZERO;
   logic [WORD_WIDTH-1:0]      csr_wdata        = '0;

   int          fail_count;
   int          pending_count;
   int unsigned cycle_count = 0;
   int          items_sent  = 0;
   bit          calm        = 1'b0;

   // pattern as last loaded, used to build lines that can match
   byte_type pat_bytes [PATTERN_BYTES];
   int       pat_used = 1;

   substring_line_matcher u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_byte_present (req_byte_present),
      .req_line_end     (req_line_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_match   (rsp_line_match),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   line_match_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_byte_present (req_byte_present),
      .req_line_end     (req_line_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_match   (rsp_line_match),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL substring_line_matcher");
         $finish;
      end
   end

   // result side backpressure
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 21);
   end

   // present one input word and hold it until taken
   task automatic send_word(input byte_type value, input logic present, input logic last);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(99) < 21) gap = $urandom_range(1, 2);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_text_byte    <= value;
      req_byte_present <= present;
      req_line_end     <= last;
      do @(posedge clock); while (!req_ready);
      if (present || last) items_sent++;
   endtask

   // stop sending and wait for every owed verdict
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type index, input logic [WORD_WIDTH-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= data;
      @(posedge clock);
   endtask

   function automatic logic [WORD_WIDTH-1:0] pattern_word(input int w);
      logic [WORD_WIDTH-1:0] packed_word;
      for (int j = 0; j < BYTES_PER_WORD; j++)
         packed_word[j*BYTE_WIDTH +: BYTE_WIDTH] = pat_bytes[w*BYTES_PER_WORD + j];
      return packed_word;
   endfunction

   // write all pattern registers while the block is idle
   task automatic load_pattern(input int len_value);
      logic [WORD_WIDTH-1:0] len_word;
      drain();
      len_word = '0;
      if ($urandom_range(1)) len_word = {$urandom, $urandom};
      len_word[LENGTH_WIDTH-1:0] = len_value[LENGTH_WIDTH-1:0];
      write_reg(REG_PATTERN_WORD_ZERO, pattern_word(0));
      write_reg(REG_PATTERN_WORD_ONE, pattern_word(1));
      write_reg(REG_PATTERN_WORD_TWO, pattern_word(2));
      write_reg(REG_PATTERN_WORD_THREE, pattern_word(3));
      write_reg(REG_PATTERN_LENGTH, len_word);
      csr_write_en <= 1'b0;
      pat_used = (len_value > PATTERN_BYTES) ? PATTERN_BYTES : len_value;
   endtask

   // random pattern; a forced length of -1 means pick one
   task automatic pick_pattern(input int forced);
      int  mode;
      int  len_value;
      int  used;
      bit  narrow;
      mode = $urandom_range(99);
      if (forced >= 0) len_value = forced;
      else if (mode < 4) len_value = 0;
      else if (mode < 45) len_value = $urandom_range(1, 4);
      else if (mode < 80) len_value = $urandom_range(5, 31);
      else if (mode < 92) len_value = PATTERN_BYTES;
      else len_value = $urandom_range(PATTERN_BYTES + 1, 63);
      used = (len_value > PATTERN_BYTES) ? PATTERN_BYTES : len_value;
      narrow = $urandom_range(1);
      foreach (pat_bytes[k])
         pat_bytes[k] = narrow ? byte_type'($urandom_range(1, 3)) : byte_type'($urandom_range(1, 255));
      // a zero inside the pattern can never match
      if (used > 0 && $urandom_range(99) < 8) pat_bytes[$urandom_range(0, used - 1)] = '0;
      load_pattern(len_value);
   endtask

   // filler mostly drawn from the pattern so partial matches are common
   function automatic byte_type filler_byte();
      if (pat_used > 0 && $urandom_range(99) < 70) return pat_bytes[$urandom_range(0, pat_used - 1)];
      if ($urandom_range(1)) return byte_type'($urandom_range(1, 3));
      return byte_type'($urandom_range(1, 255));
   endfunction

   // one text line, often with the pattern planted in it
   task automatic send_line();
      byte_type line_bytes [$];
      int       prefix;
      int       suffix;
      bit       end_on_byte;
      prefix = ($urandom_range(99) < 10) ? $urandom_range(20, 60) : $urandom_range(0, 12);
      suffix = $urandom_range(0, 10);
      repeat (prefix) line_bytes.push_back(filler_byte());
      if (pat_used > 0 && $urandom_range(99) < 55)
         for (int k = 0; k < pat_used; k++) line_bytes.push_back(pat_bytes[k]);
      repeat (suffix) line_bytes.push_back(filler_byte());
      if (line_bytes.size() > 0 && $urandom_range(99) < 15)
         line_bytes[$urandom_range(0, line_bytes.size() - 1)] = byte_type'($urandom_range(1, 255));
      if (line_bytes.size() > 0 && $urandom_range(99) < 6)
         line_bytes[$urandom_range(0, line_bytes.size() - 1)] = '0;
      end_on_byte = (line_bytes.size() > 0) && $urandom_range(1);
      foreach (line_bytes[i]) begin
         // stray word with neither byte nor line end
         if ($urandom_range(99) < 3) send_word(byte_type'($urandom), 1'b0, 1'b0);
         send_word(line_bytes[i], 1'b1, end_on_byte && (i == line_bytes.size() - 1));
      end
      if (!end_on_byte) send_word(byte_type'($urandom), 1'b0, 1'b1);
   endtask

   initial begin
      int  phase;
      int  phase_goal;
      int  stop_at;
      bit  paused;
      foreach (pat_bytes[k]) pat_bytes[k] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset pattern holds a zero byte, so nothing matches
      send_word("A", 1'b1, 1'b1);

      pat_bytes[0] = "a";
      pat_bytes[1] = "b";
      load_pattern(2);
      send_word("a", 1'b1, 1'b0);
      send_word("b", 1'b1, 1'b1);
      // empty line
      send_word(8'h00, 1'b0, 1'b1);
      // ignored word in the middle of a match
      send_word("b", 1'b1, 1'b0);
      send_word("a", 1'b1, 1'b0);
      send_word(8'hFF, 1'b0, 1'b0);
      send_word("b", 1'b1, 1'b1);
      // zero byte cuts the line before the match
      send_word("a", 1'b1, 1'b0);
      send_word(8'h00, 1'b1, 1'b0);
      send_word("b", 1'b1, 1'b0);
      send_word(8'h00, 1'b0, 1'b1);
      // line shorter than the pattern
      send_word("a", 1'b1, 1'b1);
      send_word(8'hFF, 1'b1, 1'b0);
      send_word(8'hFF, 1'b0, 1'b1);

      // empty pattern matches every line
      load_pattern(0);
      send_word(8'h00, 1'b0, 1'b1);
      send_word("q", 1'b1, 1'b1);

      pat_bytes[0] = 8'hFF;
      load_pattern(1);
      send_word(8'hFF, 1'b1, 1'b1);

      // zero byte inside the used pattern
      pat_bytes[0] = "a";
      pat_bytes[1] = 8'h00;
      load_pattern(2);
      send_word("a", 1'b1, 1'b0);
      send_word(8'h00, 1'b1, 1'b1);

      // random phases, each with its own pattern
      stop_at = items_sent + RANDOM_ITEMS;
      phase   = 0;
      paused  = 1'b0;
      while (items_sent < stop_at) begin
         case (phase)
            0:       pick_pattern(PATTERN_BYTES);
            1:       pick_pattern(63);
            default: pick_pattern(-1);
         endcase
         calm       = (phase == 2);
         phase_goal = items_sent + PHASE_ITEMS;
         while (items_sent < phase_goal) begin
            send_line();
            if (phase == 3 && !paused && items_sent > phase_goal - PHASE_ITEMS / 2) begin
               drain();
               paused = 1'b1;
            end
         end
         phase++;
      end
      calm = 1'b0;

      drain();
      if (fail_count == 0)
         $display("PASS substring_line_matcher");
      else
         $display("FAIL substring_line_matcher");
      $finish;
   end

endmodule
